// ===== rtl/rle_pkg.sv =====
package rle_pkg;

  // Field widths
  localparam int SYM_BITS    = 8;
  localparam int LENGTH_BITS = 24;
  localparam int COUNT_BITS  = 48;
  localparam int NUM_SYMS    = 1 << SYM_BITS;

  // Input item kinds; the fourth code is ignored
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_FLUSH  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Result item kinds
  localparam logic RES_RUN    = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SYM_BITS-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [SYM_BITS-1:0]    run_symbol;
    logic [LENGTH_BITS-1:0] run_length;
    logic                   continues;
    logic [COUNT_BITS-1:0]  total_bytes;
    logic [COUNT_BITS-1:0]  total_runs;
    logic [COUNT_BITS-1:0]  symbol_bytes;
    logic [COUNT_BITS-1:0]  symbol_runs;
  } out_item_t;

  // Saturating counter increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

// ===== rtl/rle_ram.sv =====
module rle_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/run_length_byte_encoder.sv =====
// Run-length byte encoder. Takes one item per clock while the output is not
// stalled (append a byte, flush the open run, or query the counters of one
// byte) and gives at most one result per item. An accepted item passes
// through the stage 1 register and then the output register, where the
// result waits until the receiver takes it. Run state and the totals live
// in registers and are updated at acceptance; the per-byte counters sit in
// one 256 x 96 synchronous RAM that is read at acceptance and written back
// for an append when it leaves stage 1, with the last write forwarded so
// that equal bytes back to back see fresh counts. Per-entry valid bits make
// every counter read as zero after reset, so there is no clearing pass. All
// counters saturate at their maximum. The RAM read-modify-write sets the
// rate of one item per cycle when the output is not stalled.
module run_length_byte_encoder import rle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RAM_W = 2 * COUNT_BITS;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SYM_BITS-1:0]    sym;
    logic                   emit;
    logic [SYM_BITS-1:0]    rec_sym;
    logic [LENGTH_BITS-1:0] rec_len;
    logic                   rec_cont;
    logic                   starts;
    logic [COUNT_BITS-1:0]  tot_bytes;
    logic [COUNT_BITS-1:0]  tot_runs;
    logic                   rd_vld;
  } s1_t;

  // Run state and totals
  logic [SYM_BITS-1:0]    open_sym_r, open_sym_nxt;
  logic [LENGTH_BITS-1:0] open_len_r, open_len_nxt;
  logic                   run_open_r, run_open_nxt;
  logic [COUNT_BITS-1:0]  byte_tot_r, byte_tot_nxt;
  logic [COUNT_BITS-1:0]  run_tot_r, run_tot_nxt;

  // Stage 1
  logic s1_valid_r, s1_valid_nxt;
  s1_t  s1_r, s1_nxt;
  logic s1_adv;

  // Counter RAM, valid bits and forwarding
  logic [NUM_SYMS-1:0]   cnt_vld_r, cnt_vld_nxt;
  logic                  fwd_valid_r, fwd_valid_nxt;
  logic [SYM_BITS-1:0]   fwd_addr_r, fwd_addr_nxt;
  logic [COUNT_BITS-1:0] fwd_bytes_r, fwd_bytes_nxt;
  logic [COUNT_BITS-1:0] fwd_runs_r, fwd_runs_nxt;
  logic                  ram_we;
  logic [RAM_W-1:0]      ram_rdata;
  logic [COUNT_BITS-1:0] cur_bytes, cur_runs, new_bytes, new_runs;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      s1_has_res;
  out_item_t s1_res;

  logic in_acc;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Stage 0: run tracking and totals
  always_comb begin
    logic match;
    open_sym_nxt = open_sym_r;
    open_len_nxt = open_len_r;
    run_open_nxt = run_open_r;
    byte_tot_nxt = byte_tot_r;
    run_tot_nxt  = run_tot_r;
    s1_nxt       = s1_r;
    match        = run_open_r && (in_data.symbol == open_sym_r);
    if (in_acc) begin
      s1_nxt.kind      = in_data.kind;
      s1_nxt.sym       = in_data.symbol;
      s1_nxt.emit      = 1'b0;
      s1_nxt.rec_sym   = open_sym_r;
      s1_nxt.rec_len   = open_len_r;
      s1_nxt.rec_cont  = 1'b0;
      s1_nxt.starts    = 1'b0;
      s1_nxt.tot_bytes = byte_tot_r;
      s1_nxt.tot_runs  = run_tot_r;
      s1_nxt.rd_vld    = cnt_vld_r[in_data.symbol];
      priority if (in_data.kind == KIND_APPEND) begin
        byte_tot_nxt = sat_inc(byte_tot_r);
        if (match) begin
          if (&open_len_r) begin
            // full chunk goes out, the run carries on
            s1_nxt.emit     = 1'b1;
            s1_nxt.rec_cont = 1'b1;
            open_len_nxt    = LENGTH_BITS'(1);
          end else begin
            open_len_nxt = open_len_r + LENGTH_BITS'(1);
          end
        end else begin
          s1_nxt.emit   = run_open_r;
          s1_nxt.starts = 1'b1;
          run_tot_nxt   = sat_inc(run_tot_r);
          open_sym_nxt  = in_data.symbol;
          open_len_nxt  = LENGTH_BITS'(1);
          run_open_nxt  = 1'b1;
        end
      end else if (in_data.kind == KIND_FLUSH) begin
        s1_nxt.emit  = run_open_r;
        run_open_nxt = 1'b0;
        open_len_nxt = '0;
      end else begin
        // query and unused code change nothing here
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  rle_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SYMS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.sym),
    .wdata ({new_bytes, new_runs}),
    .re    (in_acc),
    .raddr (in_data.symbol),
    .rdata (ram_rdata)
  );

  // Stage 1: counter values with forwarding of the last write
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_r.sym)) begin
      cur_bytes = fwd_bytes_r;
      cur_runs  = fwd_runs_r;
    end else if (s1_r.rd_vld) begin
      cur_bytes = ram_rdata[RAM_W-1:COUNT_BITS];
      cur_runs  = ram_rdata[COUNT_BITS-1:0];
    end else begin
      cur_bytes = '0;
      cur_runs  = '0;
    end
    new_bytes = sat_inc(cur_bytes);
    new_runs  = s1_r.starts ? sat_inc(cur_runs) : cur_runs;
  end

  assign ram_we = s1_valid_r && s1_adv && (s1_r.kind == KIND_APPEND);

  always_comb begin
    cnt_vld_nxt   = cnt_vld_r;
    fwd_valid_nxt = fwd_valid_r;
    fwd_addr_nxt  = fwd_addr_r;
    fwd_bytes_nxt = fwd_bytes_r;
    fwd_runs_nxt  = fwd_runs_r;
    if (ram_we) begin
      cnt_vld_nxt[s1_r.sym] = 1'b1;
      fwd_valid_nxt         = 1'b1;
      fwd_addr_nxt          = s1_r.sym;
      fwd_bytes_nxt         = new_bytes;
      fwd_runs_nxt          = new_runs;
    end
  end

  // Stage 1 result item
  always_comb begin
    s1_res     = '0;
    s1_has_res = 1'b0;
    if (s1_r.kind == KIND_QUERY) begin
      s1_has_res          = 1'b1;
      s1_res.result_kind  = RES_REPORT;
      s1_res.total_bytes  = s1_r.tot_bytes;
      s1_res.total_runs   = s1_r.tot_runs;
      s1_res.symbol_bytes = cur_bytes;
      s1_res.symbol_runs  = cur_runs;
    end else begin
      s1_has_res         = s1_r.emit;
      s1_res.result_kind = RES_RUN;
      s1_res.run_symbol  = s1_r.rec_sym;
      s1_res.run_length  = s1_r.rec_len;
      s1_res.continues   = s1_r.rec_cont;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r && s1_has_res;
      out_data_nxt  = s1_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_sym_r  <= '0;
      open_len_r  <= '0;
      run_open_r  <= 1'b0;
      byte_tot_r  <= '0;
      run_tot_r   <= '0;
      s1_valid_r  <= 1'b0;
      cnt_vld_r   <= '0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      open_sym_r  <= open_sym_nxt;
      open_len_r  <= open_len_nxt;
      run_open_r  <= run_open_nxt;
      byte_tot_r  <= byte_tot_nxt;
      run_tot_r   <= run_tot_nxt;
      s1_valid_r  <= s1_valid_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    fwd_addr_r  <= fwd_addr_nxt;
    fwd_bytes_r <= fwd_bytes_nxt;
    fwd_runs_r  <= fwd_runs_nxt;
    out_data_r  <= out_data_nxt;
  end

  // An open run always holds at least one byte, a closed one none
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (run_open_r == (open_len_r != '0)))
    else $error("open run length out of step with run flag");

  // A counter write-back is visible to the forwarding path on the next cycle
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (fwd_valid_r && (fwd_addr_r == $past(s1_r.sym))))
    else $error("forwarding register missed a counter write");

  // Run records never carry an empty chunk
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.result_kind == RES_RUN)) |-> (out_data_r.run_length != '0))
    else $error("run record with zero length");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rle_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;

  // fourth kind code, ignored by the block
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [LENGTH_BITS-1:0] CHUNK_FULL = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_TOP  = '1;

  typedef struct {
    in_item_t  item;
    bit        typed;
    bit        has;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  run_length_byte_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // encoder state as predicted
  logic [SYM_BITS-1:0]    open_sym;
  logic [LENGTH_BITS-1:0] open_len;
  bit                     run_live;
  logic [COUNT_BITS-1:0]  bytes_seen;
  logic [COUNT_BITS-1:0]  runs_seen;
  logic [COUNT_BITS-1:0]  sym_bytes [NUM_SYMS];
  logic [COUNT_BITS-1:0]  sym_runs  [NUM_SYMS];

  // results still to come, oldest first
  out_item_t pending_results[$];

  // directed stimulus table
  stim_row_t rows[$];

  // side information for the item now on the input
  bit        cur_typed;
  bit        cur_has;
  out_item_t cur_want;

  bit hold_req;
  bit tx_burst;
  bit rx_burst;

  int fails;
  int cycles;
  int items_in;
  int run_records;
  int reports;
  int stall_cycles;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_TOP) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic out_item_t run_rec(input logic [SYM_BITS-1:0] s,
                                        input logic [LENGTH_BITS-1:0] len,
                                        input logic cont);
    out_item_t r;
    r = '0;
    r.result_kind = RES_RUN;
    r.run_symbol  = s;
    r.run_length  = len;
    r.continues   = cont;
    return r;
  endfunction

  function automatic out_item_t report_rec(input logic [COUNT_BITS-1:0] tb_cnt,
                                           input logic [COUNT_BITS-1:0] tr_cnt,
                                           input logic [COUNT_BITS-1:0] sb_cnt,
                                           input logic [COUNT_BITS-1:0] sr_cnt);
    out_item_t r;
    r = '0;
    r.result_kind  = RES_REPORT;
    r.total_bytes  = tb_cnt;
    r.total_runs   = tr_cnt;
    r.symbol_bytes = sb_cnt;
    r.symbol_runs  = sr_cnt;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input logic [1:0] kind, input logic [SYM_BITS-1:0] sym,
                                  input bit typed, input bit has, input out_item_t want);
    stim_row_t row;
    row.item.kind   = kind;
    row.item.symbol = sym;
    row.typed       = typed;
    row.has         = has;
    row.want        = want;
    rows.insert(rows.size(), row);
  endfunction

  // Advance the predicted encoder by one item; has says whether a result follows.
  // Splitting at a full chunk and counter saturation are modelled, though
  // neither is reachable in a run of this length.
  function automatic void encode_item(input in_item_t it, output bit has,
                                      output out_item_t res);
    logic [SYM_BITS-1:0] s;
    s   = it.symbol;
    has = 1'b0;
    res = '0;
    case (it.kind)
      KIND_APPEND: begin
        bytes_seen   = bump(bytes_seen);
        sym_bytes[s] = bump(sym_bytes[s]);
        if (run_live && s == open_sym) begin
          if (open_len == CHUNK_FULL) begin
            res      = run_rec(open_sym, CHUNK_FULL, 1'b1);
            has      = 1'b1;
            open_len = LENGTH_BITS'(1);
          end else begin
            open_len = open_len + LENGTH_BITS'(1);
          end
        end else begin
          if (run_live) begin
            res = run_rec(open_sym, open_len, 1'b0);
            has = 1'b1;
          end
          runs_seen   = bump(runs_seen);
          sym_runs[s] = bump(sym_runs[s]);
          open_sym    = s;
          open_len    = LENGTH_BITS'(1);
          run_live    = 1'b1;
        end
      end
      KIND_FLUSH: begin
        if (run_live) begin
          res      = run_rec(open_sym, open_len, 1'b0);
          has      = 1'b1;
          run_live = 1'b0;
          open_len = '0;
        end
      end
      KIND_QUERY: begin
        res = report_rec(bytes_seen, runs_seen, sym_bytes[s], sym_runs[s]);
        has = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: %p", got);
      fails++;
    end else begin
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        fails++;
      end
      if (got.run_symbol !== want.run_symbol) begin
        $error("run_symbol: expected %0d, got %0d", want.run_symbol, got.run_symbol);
        fails++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
        fails++;
      end
      if (got.continues !== want.continues) begin
        $error("continues: expected %0d, got %0d", want.continues, got.continues);
        fails++;
      end
      if (got.total_bytes !== want.total_bytes) begin
        $error("total_bytes: expected %0d, got %0d", want.total_bytes, got.total_bytes);
        fails++;
      end
      if (got.total_runs !== want.total_runs) begin
        $error("total_runs: expected %0d, got %0d", want.total_runs, got.total_runs);
        fails++;
      end
      if (got.symbol_bytes !== want.symbol_bytes) begin
        $error("symbol_bytes: expected %0d, got %0d", want.symbol_bytes, got.symbol_bytes);
        fails++;
      end
      if (got.symbol_runs !== want.symbol_runs) begin
        $error("symbol_runs: expected %0d, got %0d", want.symbol_runs, got.symbol_runs);
        fails++;
      end
    end
  endtask

  // Handshake monitor: checks results, predicts accepted items, guards the run
  always @(posedge clk) begin
    bit        has;
    out_item_t res;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (out_data.result_kind === RES_REPORT) reports++;
        else run_records++;
        check_result(out_data);
      end
      if (in_valid && in_ready === 1'b1) begin
        items_in++;
        encode_item(in_data, has, res);
        if (cur_typed) begin
          has = cur_has;
          res = cur_want;
        end
        if (has) pending_results.insert(pending_results.size(), res);
      end
      if (in_valid && in_ready !== 1'b1) stall_cycles++;
    end
  end

  // Offer one item; starts and ends on a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [SYM_BITS-1:0] sym);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.kind   <= kind;
    in_data.symbol <= sym;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender stops until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int wait_n;
    int taken;
    out_ready <= 1'b0;
    rx_burst  = 1'b0;
    taken     = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        wait_n = rx_burst ? 0 : $urandom_range(0, 9);
        if (wait_n > 0) begin
          out_ready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
      taken++;
      if (taken % 80 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Stimulus
  initial begin
    stim_row_t           r;
    int                  n;
    int                  pick;
    int                  len;
    int                  next_phase;
    bit                  held;
    bit                  drained;
    logic [SYM_BITS-1:0] sym;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    hold_req  = 1'b0;
    tx_burst  = 1'b0;
    cur_typed = 1'b0;
    cur_has   = 1'b0;
    cur_want  = '0;
    fails = 0; cycles = 0; items_in = 0;
    run_records = 0; reports = 0; stall_cycles = 0;

    open_sym   = '0;
    open_len   = '0;
    run_live   = 1'b0;
    bytes_seen = '0;
    runs_seen  = '0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      sym_bytes[i] = '0;
      sym_runs[i]  = '0;
    end

    // Directed table; typed rows carry their own expectation
    // counters read zero straight after reset
    add_row(KIND_QUERY, 8'h00, 1'b1, 1'b1, report_rec('0, '0, '0, '0));
    add_row(KIND_QUERY, 8'hFF, 1'b1, 1'b1, report_rec('0, '0, '0, '0));
    // flush with nothing open, and the unused kind: no result
    add_row(KIND_FLUSH, 8'h00, 1'b1, 1'b0, '0);
    add_row(KIND_UNUSED, 8'hAA, 1'b1, 1'b0, '0);
    // byte zero is an ordinary symbol
    add_row(KIND_APPEND, 8'h00, 1'b1, 1'b0, '0);
    add_row(KIND_APPEND, 8'h00, 1'b1, 1'b0, '0);
    add_row(KIND_APPEND, 8'hFF, 1'b1, 1'b1, run_rec(8'h00, LENGTH_BITS'(2), 1'b0));
    add_row(KIND_FLUSH, 8'h00, 1'b1, 1'b1, run_rec(8'hFF, LENGTH_BITS'(1), 1'b0));
    add_row(KIND_FLUSH, 8'h3C, 1'b1, 1'b0, '0);
    add_row(KIND_QUERY, 8'h00, 1'b1, 1'b1,
            report_rec(COUNT_BITS'(3), COUNT_BITS'(2), COUNT_BITS'(2), COUNT_BITS'(1)));
    // an append after a flush opens and counts a new run
    add_row(KIND_APPEND, 8'hFF, 1'b1, 1'b0, '0);
    add_row(KIND_QUERY, 8'hFF, 1'b1, 1'b1,
            report_rec(COUNT_BITS'(4), COUNT_BITS'(3), COUNT_BITS'(2), COUNT_BITS'(2)));
    add_row(KIND_APPEND, 8'h55, 1'b0, 1'b0, '0);
    add_row(KIND_APPEND, 8'hAA, 1'b0, 1'b0, '0);
    add_row(KIND_APPEND, 8'hAA, 1'b0, 1'b0, '0);
    add_row(KIND_APPEND, 8'hAA, 1'b0, 1'b0, '0);
    add_row(KIND_APPEND, 8'h55, 1'b0, 1'b0, '0);
    add_row(KIND_UNUSED, 8'h55, 1'b1, 1'b0, '0);
    add_row(KIND_QUERY, 8'hAA, 1'b0, 1'b0, '0);
    add_row(KIND_FLUSH, 8'hFF, 1'b0, 1'b0, '0);
    add_row(KIND_QUERY, 8'h55, 1'b0, 1'b0, '0);
    add_row(KIND_APPEND, 8'h80, 1'b0, 1'b0, '0);
    add_row(KIND_QUERY, 8'h7F, 1'b0, 1'b0, '0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      r         = rows[i];
      cur_typed = r.typed;
      cur_has   = r.has;
      cur_want  = r.want;
      send_item(r.item.kind, r.item.symbol);
    end
    cur_typed = 1'b0;
    drain_results();

    // Random part: mostly runs of equal bytes, with flushes, queries and noise
    n          = 0;
    next_phase = 120;
    held       = 1'b0;
    drained    = 1'b0;
    while (n < RANDOM_ITEMS) begin
      if (n >= next_phase) begin
        tx_burst   = ($urandom_range(0, 2) == 0);
        next_phase = next_phase + 120;
      end
      if (!held && n >= 500) begin
        // long receiver hold-off while queries keep arriving back to back
        held     = 1'b1;
        hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (40) begin
          send_item(KIND_QUERY, 8'($urandom_range(0, 255)));
          n++;
        end
      end
      if (!drained && n >= 900) begin
        drained = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sym = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        repeat (len) send_item(KIND_APPEND, sym);
        n = n + len;
      end else if (pick < 77) begin
        send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
        n++;
      end else if (pick < 95) begin
        sym = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        send_item(KIND_QUERY, sym);
        n++;
      end else begin
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // Wait for the tail, then wait quietly for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items accepted, %0d run records and %0d counter reports checked",
             items_in, run_records, reports);
    $display("input held back for %0d cycles; %0d mismatches", stall_cycles, fails);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
